// ===== hw/rtl/pulse_width_single_wire_sender_macros.svh =====
// assertion helpers for the rtl
`ifndef PULSE_WIDTH_SINGLE_WIRE_SENDER_MACROS_SVH
`define PULSE_WIDTH_SINGLE_WIRE_SENDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PWSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwss assertion failed");

// next-cycle implication, checked outside reset
`define PWSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwss assertion failed");

`endif

// ===== hw/rtl/pwss_pkg.sv =====
`timescale 1ns / 1ps

package pwss_pkg;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LEAD  = 2'd0;
    localparam logic [1:0] CFG_SHORT = 2'd1;
    localparam logic [1:0] CFG_LONG  = 2'd2;
    localparam logic [1:0] CFG_STOP  = 2'd3;

    // configuration reset values
    localparam logic [5:0] LEAD_RST  = 6'd40;
    localparam logic [4:0] SHORT_RST = 5'd4;
    localparam logic [4:0] LONG_RST  = 5'd8;
    localparam logic [5:0] STOP_RST  = 6'd16;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_BITS = 2'd1,
        PH_STOP = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_out_item;

endpackage

// ===== hw/rtl/pulse_width_single_wire_sender.sv =====
`timescale 1ns / 1ps
// pulse-width coded single wire sender
// input channel: i_in_valid / o_in_stall carry a command transaction, action is
//   tick (advance the frame one time step), start (latch data_word and arm) or
//   stop (disarm and freeze the line and counters where they are)
// output channel: o_out_valid / i_out_stall carry one result transaction per
//   command: the wire level after it, busy while armed, and frame_done on the
//   tick that closes the final low phase
// config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (lead, short, long, stop tick counts); write only while idle
// result: the result of a command is registered and on the output in the cycle after it is taken
// throughput: one command per cycle while o_in_stall is low; the whole state update is one pass of
//   counter compare logic ahead of the state and result registers
// stall: the result register holds while i_out_stall is high; one more command
//   is still taken while the register drains, o_in_stall rises only when a
//   result waits and the receiver stalls
// reset: synchronous, active low; sender disarmed, wire idle high, config
//   registers back to lead 40, short 4, long 8, stop 16, no result pending
`include "pulse_width_single_wire_sender_macros.svh"

module pulse_width_single_wire_sender #(
    parameter int WORD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pwss_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pwss_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [5:0]          i_cfg_data
);

    // configuration registers
    logic [5:0] r_lead_ticks;
    logic [4:0] r_short_ticks;
    logic [4:0] r_long_ticks;
    logic [5:0] r_stop_ticks;

    // sender state
    logic             r_armed,       n_armed;
    logic             r_fresh,       n_fresh;
    pwss_pkg::t_phase r_phase,       n_phase;
    logic             r_level_half,  n_level_half;
    logic [6:0]       r_lead_count,  n_lead_count;   // counts up to 64
    logic [5:0]       r_width_count, n_width_count;
    logic [4:0]       r_bit_index,   n_bit_index;
    logic [15:0]      r_word,        n_word;
    logic             r_wire,        n_wire;
    logic             n_done;

    // result register
    logic                r_out_valid;
    pwss_pkg::t_out_item r_out;
    pwss_pkg::t_out_item n_out;

    logic       w_accept;
    logic       w_tick;
    logic [5:0] w_wc_inc;
    logic [4:0] w_bi_inc;
    logic [4:0] w_bit_target;

    // a waiting result blocks new commands only while the receiver stalls
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_tick      = w_accept && (i_in_data.action == pwss_pkg::ACT_TICK);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // width counter and bit index step, taken after a possible restart clear
    assign w_wc_inc     = (r_fresh ? 6'd0 : r_width_count) + 6'd1;
    assign w_bi_inc     = (r_fresh ? 5'd0 : r_bit_index) + 5'd1;
    // high phase of a data bit: long for a one, short for a zero
    assign w_bit_target = r_word[r_bit_index[3:0]] ? r_long_ticks : r_short_ticks;

    // next state and result
    always_comb begin
        n_armed       = r_armed;
        n_fresh       = r_fresh;
        n_phase       = r_phase;
        n_level_half  = r_level_half;
        n_lead_count  = r_lead_count;
        n_width_count = r_width_count;
        n_bit_index   = r_bit_index;
        n_word        = r_word;
        n_wire        = r_wire;
        n_done        = 1'b0;

        if (w_tick && r_armed) begin
            // first tick of a frame clears the counters
            if (r_fresh) begin
                n_fresh       = 1'b0;
                n_lead_count  = 7'd0;
                n_width_count = 6'd0;
                n_level_half  = 1'b0;
                n_bit_index   = 5'd0;
                n_phase       = pwss_pkg::PH_LEAD;
            end
            case (n_phase)
                pwss_pkg::PH_LEAD: begin
                    if (n_lead_count <= {1'b0, r_lead_ticks}) begin
                        // idle lead time, line untouched
                        n_lead_count = n_lead_count + 7'd1;
                    end else if (!n_level_half) begin
                        // start pulse low half
                        n_wire        = 1'b0;
                        n_width_count = w_wc_inc;
                        if (w_wc_inc > {1'b0, r_long_ticks}) begin
                            n_wire        = 1'b1;
                            n_level_half  = 1'b1;
                            n_width_count = 6'd0;
                        end
                    end else begin
                        // start pulse high half
                        n_width_count = w_wc_inc;
                        if (w_wc_inc == {1'b0, r_long_ticks}) begin
                            n_wire        = 1'b0;
                            n_level_half  = 1'b0;
                            n_phase       = pwss_pkg::PH_BITS;
                            n_width_count = 6'd0;
                        end
                    end
                end
                pwss_pkg::PH_BITS: begin
                    n_width_count = w_wc_inc;
                    if (!n_level_half) begin
                        if (w_wc_inc == {1'b0, r_short_ticks}) begin
                            n_wire        = 1'b1;
                            n_level_half  = 1'b1;
                            n_width_count = 6'd0;
                        end
                    end else if (w_wc_inc == {1'b0, w_bit_target}) begin
                        // bit done, move to the next or to the closing low
                        n_wire        = 1'b0;
                        n_level_half  = 1'b0;
                        n_width_count = 6'd0;
                        n_bit_index   = w_bi_inc;
                        if (32'(w_bi_inc) >= 32'(WORD_BITS)) begin
                            n_bit_index = 5'd0;
                            n_phase     = pwss_pkg::PH_STOP;
                        end
                    end
                end
                pwss_pkg::PH_STOP: begin
                    n_wire        = 1'b0;
                    n_width_count = w_wc_inc;
                    if (w_wc_inc == r_stop_ticks) begin
                        // frame complete, release the line
                        n_wire        = 1'b1;
                        n_width_count = 6'd0;
                        n_phase       = pwss_pkg::PH_LEAD;
                        n_bit_index   = 5'd0;
                        n_armed       = 1'b0;
                        n_fresh       = 1'b1;
                        n_done        = 1'b1;
                    end
                end
                default: begin
                    // unused phase code, hold
                end
            endcase
        end else if (w_accept) begin
            case (i_in_data.action)
                pwss_pkg::ACT_START: begin
                    n_word  = i_in_data.data_word;
                    n_fresh = 1'b1;
                    n_armed = 1'b1;
                end
                pwss_pkg::ACT_STOP: begin
                    n_armed = 1'b0;
                end
                default: begin
                    // tick while disarmed or unused code: no change
                end
            endcase
        end

        n_out.line_level = n_wire;
        n_out.busy_res   = n_armed;
        n_out.frame_done = n_done;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_ticks  <= pwss_pkg::LEAD_RST;
            r_short_ticks <= pwss_pkg::SHORT_RST;
            r_long_ticks  <= pwss_pkg::LONG_RST;
            r_stop_ticks  <= pwss_pkg::STOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwss_pkg::CFG_LEAD:  r_lead_ticks  <= i_cfg_data;
                pwss_pkg::CFG_SHORT: r_short_ticks <= i_cfg_data[4:0];
                pwss_pkg::CFG_LONG:  r_long_ticks  <= i_cfg_data[4:0];
                pwss_pkg::CFG_STOP:  r_stop_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sender state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_fresh       <= 1'b1;
            r_phase       <= pwss_pkg::PH_LEAD;
            r_level_half  <= 1'b0;
            r_lead_count  <= 7'd0;
            r_width_count <= 6'd0;
            r_bit_index   <= 5'd0;
            r_wire        <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_armed       <= n_armed;
            r_fresh       <= n_fresh;
            r_phase       <= n_phase;
            r_level_half  <= n_level_half;
            r_lead_count  <= n_lead_count;
            r_width_count <= n_width_count;
            r_bit_index   <= n_bit_index;
            r_wire        <= n_wire;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // every taken command leaves a result behind it
    `PWSS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, r_out_valid)
    // a finished frame shows the released line and a disarmed sender
    `PWSS_ASSERT_IMPL(a_done_release, i_clk, i_rst_n, r_out_valid && r_out.frame_done,
        r_out.line_level && !r_out.busy_res)
    // a tick while disarmed leaves the line and counters alone
    `PWSS_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n, w_tick && !r_armed,
        $stable(r_wire) && $stable(r_width_count) && $stable(r_phase))
    // bit index stays inside the word
    `PWSS_ASSERT_IMPL(a_bit_range, i_clk, i_rst_n, 1'b1, 32'(r_bit_index) < 32'(WORD_BITS))

endmodule

// ===== dv/tb_pulse_width_single_wire_sender.sv =====
`timescale 1ns / 1ps

module tb_pulse_width_single_wire_sender;
    import pwss_pkg::*;

    localparam int         WORD_BITS  = 16;
    localparam logic [1:0] ACT_NOP    = 2'd3;  // unused action code, must do nothing
    localparam int         SETTLE     = 3;     // idle cycles before a register write
    localparam int         LONG_HOLD  = 80;    // receiver hold-off, enough to back up the input
    localparam int         DRAIN_WAIT = 10;    // cycles after the last result

    // ------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_data = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_LEAD;
    logic [5:0] cfg_data = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    pulse_width_single_wire_sender #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // sender predictor: own copy of the timing registers and frame state
    // ------------------------------------------------------------------
    logic [5:0]  cfg_lead;
    logic [4:0]  cfg_short;
    logic [4:0]  cfg_long;
    logic [5:0]  cfg_stop;

    logic        s_armed;
    logic        s_fresh;      // counters clear on the next tick
    logic        s_half;       // 0 low half, 1 high half of a pulse
    logic        s_line;
    t_phase      s_phase;
    logic [6:0]  s_lead_cnt;   // one bit wider so lead 63 still counts 64 idle ticks
    logic [5:0]  s_width;      // wraps at 64, which makes a zero width last 64 counts
    logic [4:0]  s_bit;
    logic [15:0] s_word;

    function automatic void reset_sender();
        cfg_lead   = LEAD_RST;
        cfg_short  = SHORT_RST;
        cfg_long   = LONG_RST;
        cfg_stop   = STOP_RST;
        s_armed    = 1'b0;
        s_fresh    = 1'b1;
        s_half     = 1'b0;
        s_line     = 1'b1;
        s_phase    = PH_LEAD;
        s_lead_cnt = '0;
        s_width    = '0;
        s_bit      = '0;
        s_word     = '0;
    endfunction

    function automatic void write_timing(logic [1:0] idx, logic [5:0] val);
        case (idx)
            CFG_LEAD:  cfg_lead  = val;
            CFG_SHORT: cfg_short = val[4:0];
            CFG_LONG:  cfg_long  = val[4:0];
            CFG_STOP:  cfg_stop  = val;
            default: ;
        endcase
    endfunction

    // count one more unit of the current pulse, true when the width is reached
    function automatic logic width_reached(logic [5:0] target);
        s_width = s_width + 6'd1;
        return s_width == target;
    endfunction

    // one time step of the frame, true on the tick that ends the closing low
    function automatic logic tick_sender();
        logic cur_bit;
        if (!s_armed) return 1'b0;
        if (s_fresh) begin
            s_fresh    = 1'b0;
            s_lead_cnt = '0;
            s_width    = '0;
            s_half     = 1'b0;
            s_bit      = '0;
            s_phase    = PH_LEAD;
        end
        case (s_phase)
            PH_LEAD: begin
                // idle lead-in, then start pulse low then high
                if (s_lead_cnt <= {1'b0, cfg_lead}) begin
                    s_lead_cnt = s_lead_cnt + 7'd1;
                    return 1'b0;
                end
                if (!s_half) begin
                    s_line  = 1'b0;
                    s_width = s_width + 6'd1;
                    if (s_width > {1'b0, cfg_long}) begin
                        s_line  = 1'b1;
                        s_half  = 1'b1;
                        s_width = '0;
                    end
                end else if (width_reached({1'b0, cfg_long})) begin
                    s_line  = 1'b0;
                    s_half  = 1'b0;
                    s_phase = PH_BITS;
                    s_width = '0;
                end
            end
            PH_BITS: begin
                if (!s_half) begin
                    if (width_reached({1'b0, cfg_short})) begin
                        s_line  = 1'b1;
                        s_half  = 1'b1;
                        s_width = '0;
                    end
                end else begin
                    cur_bit = s_word[s_bit[3:0]];
                    if (width_reached({1'b0, cur_bit ? cfg_long : cfg_short})) begin
                        s_line  = 1'b0;
                        s_half  = 1'b0;
                        s_width = '0;
                        s_bit   = s_bit + 5'd1;
                        if (s_bit >= WORD_BITS) begin
                            s_bit   = '0;
                            s_phase = PH_STOP;
                        end
                    end
                end
            end
            PH_STOP: begin
                s_line = 1'b0;
                if (width_reached(cfg_stop)) begin
                    s_line  = 1'b1;
                    s_width = '0;
                    s_phase = PH_LEAD;
                    s_bit   = '0;
                    s_armed = 1'b0;
                    s_fresh = 1'b1;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_out_item advance_sender(t_in_item cmd);
        t_out_item res;
        logic      done;
        done = 1'b0;
        case (cmd.action)
            ACT_TICK:  done = tick_sender();
            ACT_START: begin
                s_word  = cmd.data_word;
                s_fresh = 1'b1;
                s_armed = 1'b1;
            end
            ACT_STOP:  s_armed = 1'b0;
            default: ;  // unused code leaves everything as is
        endcase
        res.line_level = s_line;
        res.busy_res   = s_armed;
        res.frame_done = done;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // command list: transactions and register writes in order
    // ------------------------------------------------------------------
    typedef enum logic {
        CMD_ITEM,
        CFG_WRITE
    } t_entry_kind;

    typedef struct {
        t_entry_kind kind;
        t_in_item    cmd;
        int          gap;      // idle cycles after this transaction
        logic        kick;     // start the long receiver hold-off
        logic [1:0]  idx;
        logic [5:0]  val;
    } t_cmd_entry;

    t_cmd_entry cmd_queue[$];
    t_out_item  predicted_status[$];
    int         n_errors = 0;

    // timing as the list builder sees it, used to size whole frames
    logic [5:0] g_lead  = LEAD_RST;
    logic [4:0] g_short = SHORT_RST;
    logic [4:0] g_long  = LONG_RST;
    logic [5:0] g_stop  = STOP_RST;
    logic       g_burst = 1'b0;
    logic       g_force_burst = 1'b0;
    logic       g_kick_next = 1'b0;
    int         n_built = 0;

    task automatic add_cmd(logic [1:0] act, logic [15:0] word);
        t_cmd_entry e;
        e.kind           = CMD_ITEM;
        e.cmd.action     = act;
        e.cmd.data_word  = word;
        e.gap            = (g_burst || g_force_burst) ? 0 : $urandom_range(0, 8);
        e.kick           = g_kick_next;
        e.idx            = CFG_LEAD;
        e.val            = '0;
        g_kick_next      = 1'b0;
        cmd_queue.push_back(e);
        n_built++;
        // switch between back-to-back stretches and gappy stretches now and then
        if ($urandom_range(0, 31) == 0) g_burst = !g_burst;
    endtask

    task automatic add_tick();
        add_cmd(ACT_TICK, 16'($urandom));
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [5:0] val);
        t_cmd_entry e;
        e.kind = CFG_WRITE;
        e.cmd  = '0;
        e.gap  = 0;
        e.kick = 1'b0;
        e.idx  = idx;
        e.val  = val;
        cmd_queue.push_back(e);
        case (idx)
            CFG_LEAD:  g_lead  = val;
            CFG_SHORT: g_short = val[4:0];
            CFG_LONG:  g_long  = val[4:0];
            CFG_STOP:  g_stop  = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(int lead, int short_w, int long_w, int stop_w);
        add_cfg(CFG_LEAD, 6'(lead));
        add_cfg(CFG_SHORT, 6'(short_w));
        add_cfg(CFG_LONG, 6'(long_w));
        add_cfg(CFG_STOP, 6'(stop_w));
    endtask

    // a zero width wraps the counter and lasts 64 counts
    function automatic int span(logic [5:0] t);
        return (t == 0) ? 64 : int'(t);
    endfunction

    // ticks from start to frame_done with the current timing
    function automatic int frame_ticks(logic [15:0] w);
        int n;
        n = int'(g_lead) + 1 + int'(g_long) + 1 + span({1'b0, g_long}) + span(g_stop);
        for (int i = 0; i < WORD_BITS; i++)
            n += span({1'b0, g_short}) + span({1'b0, w[i] ? g_long : g_short});
        return n;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly complete frames with random words; the rest is cut short by
    // stop or restart, or plain noise
    task automatic build_frames(int budget);
        int          first;
        int          left;
        int          len;
        int          cut;
        int          r;
        logic [15:0] w;
        first = n_built;
        while (n_built - first < budget) begin
            left = budget - (n_built - first);
            r    = $urandom_range(0, 99);
            w    = pick_word();
            len  = frame_ticks(w);
            if (r < 70 && len <= left) begin
                add_cmd(ACT_START, w);
                repeat (len) add_tick();
                repeat ($urandom_range(0, 3)) add_tick();  // ticks while disarmed
            end else if (r < 93) begin
                cut = (len - 1 < left) ? len - 1 : left;
                add_cmd(ACT_START, w);
                repeat ($urandom_range(1, cut)) add_tick();
                // either freeze mid-frame or let the next start restart it
                if ($urandom_range(0, 1)) begin
                    add_cmd(ACT_STOP, 16'($urandom));
                    repeat ($urandom_range(0, 3)) add_tick();
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    add_cmd(2'($urandom_range(0, 3)), 16'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: launches transactions and register writes, predicts results
    // ------------------------------------------------------------------
    logic hold_kick = 1'b0;
    int   gap_left = 0;
    int   quiet_cycles = 0;

    always @(posedge clk) begin
        t_cmd_entry head;
        logic       nxt_valid;
        logic       nxt_we;
        logic       nxt_kick;
        if (!rst_n) begin
            reset_sender();
            in_valid     <= 1'b0;
            cfg_we       <= 1'b0;
            hold_kick    <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            nxt_valid = in_valid;
            nxt_we    = 1'b0;
            nxt_kick  = 1'b0;
            // transaction taken at this edge: predict its result now
            if (in_valid && !o_in_stall) begin
                predicted_status.push_back(advance_sender(in_data));
                nxt_valid = 1'b0;
            end
            if (predicted_status.size() == 0 && !o_out_valid && !in_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_valid && cmd_queue.size() != 0) begin
                head = cmd_queue[0];
                if (head.kind == CFG_WRITE) begin
                    // registers change only with the block drained and idle
                    if (quiet_cycles >= SETTLE) begin
                        write_timing(head.idx, head.val);
                        nxt_we    = 1'b1;
                        cfg_index <= head.idx;
                        cfg_data  <= head.val;
                        void'(cmd_queue.pop_front());
                    end
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    in_data   <= head.cmd;
                    nxt_valid = 1'b1;
                    nxt_kick  = head.kick;
                    gap_left  = head.gap;
                    void'(cmd_queue.pop_front());
                end
            end
            in_valid  <= nxt_valid;
            cfg_we    <= nxt_we;
            hold_kick <= nxt_kick;
        end
    end

    // ------------------------------------------------------------------
    // monitor: random result stalls, long hold-off, field checks
    // ------------------------------------------------------------------
    int   stall_left = 0;
    int   hold_left = 0;
    int   n_results = 0;
    logic rx_burst = 1'b0;

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (predicted_status.size() == 0) begin
                    $error("result transaction with nothing predicted");
                    n_errors++;
                end else begin
                    want = predicted_status.pop_front();
                    if (o_out_data.line_level !== want.line_level) begin
                        $error("line_level: expected %0b, got %0b",
                               want.line_level, o_out_data.line_level);
                        n_errors++;
                    end
                    if (o_out_data.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, o_out_data.busy_res);
                        n_errors++;
                    end
                    if (o_out_data.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, o_out_data.frame_done);
                        n_errors++;
                    end
                end
                n_results++;
                if (n_results % 48 == 0) rx_burst = 1'($urandom_range(0, 1));
                stall_left = rx_burst ? 0 : $urandom_range(0, 8);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            // long hold-off while the sender keeps pushing back to back
            if (hold_kick)
                hold_left = LONG_HOLD;
            else if (hold_left != 0)
                hold_left--;
            out_stall <= (stall_left != 0) || (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: reset timing, every action, word extremes, freeze and restart
        add_cmd(ACT_NOP, 16'hFFFF);
        add_tick();                        // tick while disarmed
        add_cmd(ACT_STOP, 16'h0000);       // stop while disarmed
        add_cmd(ACT_START, 16'hFFFF);
        repeat (6) add_tick();
        add_cmd(ACT_START, 16'h0000);      // restart while sending
        repeat (3) add_tick();
        add_cmd(ACT_STOP, 16'hFFFF);
        repeat (2) add_tick();             // frozen, nothing moves
        add_cmd(ACT_NOP, 16'h0000);
        add_cmd(ACT_START, 16'h8001);
        repeat (3) add_tick();
        add_cmd(ACT_NOP, 16'h5A5A);
        build_frames(30);

        // shortest timing, with the long receiver hold-off up front
        set_timing(0, 1, 1, 1);
        g_force_burst = 1'b1;
        g_kick_next   = 1'b1;
        build_frames(100);
        g_force_burst = 1'b0;

        // small random timing
        set_timing($urandom_range(0, 7), $urandom_range(1, 3),
                   $urandom_range(1, 4), $urandom_range(1, 8));
        build_frames(80);

        // longest lead, closing low wraps to 64 counts
        set_timing(63, 1, 1, 0);
        build_frames(170);

        // zero short and long widths wrap as well
        set_timing(1, 0, 0, 2);
        build_frames(70);

        // widest bit and stop widths
        set_timing(0, 31, 31, 63);
        build_frames(100);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || in_valid || predicted_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
